// ----- src/adsc_pkg.sv -----
// Package for the averaged duty slew controller.
// Holds the item structs, level widths, register indexes and reset values.
// No dependencies.
`default_nettype none

package adsc_pkg;

    localparam int LEVEL_W          = 10;
    localparam int SAMPLE_COUNT_DEF = 16;
    localparam int LEVEL_MAX        = (1 << LEVEL_W) - 1;

    typedef logic [LEVEL_W-1:0] t_level;

    // request kinds carried in req_type
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING = 1'b1;

    localparam t_level DUTY_FLOOR_RST   = '0;
    localparam t_level DUTY_CEILING_RST = t_level'(LEVEL_MAX);

    // distance / 10 as (distance * 3277) >> 15, exact for 10-bit distances
    localparam int SLEW_RECIP_W = 12;
    localparam logic [SLEW_RECIP_W-1:0] SLEW_RECIP = 12'd3277;
    localparam int SLEW_SHIFT = 15;
    localparam t_level MIN_STEP = t_level'(1);

    typedef struct packed {
        logic   req_type;
        t_level sensor_value;
    } t_in_item;

    typedef struct packed {
        t_level duty_level;
        t_level mean_level;
    } t_out_item;

endpackage

`default_nettype wire

// ----- src/averaged_duty_slew_controller.sv -----
// Top level of the averaged duty slew controller: history line of sample
// cells with a running total, mean stage, slew stage and output register.
// Depends on adsc_pkg, adsc_cell and adsc_slew.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One beat per cycle while o_in_ready is high. A sample beat shifts the cell
// line and updates the running total in its accept cycle and makes no result.
// An update beat registers the mean (one constant-reciprocal multiply), then
// slews the duty and lands in the output register. Reset clears the cells,
// total, duty and valids and sets the limit registers to their reset values.
// A stalled output register holds the mean stage; input ready drops only
// when both are full.
`default_nettype none

module averaged_duty_slew_controller #(
    parameter int SAMPLE_COUNT = adsc_pkg::SAMPLE_COUNT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire adsc_pkg::t_in_item                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output adsc_pkg::t_out_item                     o_out_data,
    input  wire logic                               i_cfg_we,
    input  wire logic [adsc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire adsc_pkg::t_level                   i_cfg_data
);

    localparam int TOT_W   = $clog2(SAMPLE_COUNT * adsc_pkg::LEVEL_MAX + 1);
    localparam int LOG_N   = $clog2(SAMPLE_COUNT);
    localparam int SHIFT_K = TOT_W + LOG_N;
    localparam int RECIP_W = SHIFT_K + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT_K) + longint'(SAMPLE_COUNT) - 64'd1) / longint'(SAMPLE_COUNT);
    localparam int PROD_W  = TOT_W + RECIP_W;

    // history line
    adsc_pkg::t_level w_cell_in  [SAMPLE_COUNT];
    adsc_pkg::t_level w_cell_out [SAMPLE_COUNT];

    logic               w_accept;
    logic               w_shift;
    logic               w_advance;
    logic [TOT_W-1:0]   r_total;
    logic [TOT_W-1:0]   n_total;
    logic [PROD_W-1:0]  w_prod;
    adsc_pkg::t_level   w_mean;

    logic               r_s1_valid;
    adsc_pkg::t_level   r_s1_mean;
    adsc_pkg::t_level   r_duty;
    adsc_pkg::t_level   w_duty_next;
    logic               r_out_valid;
    adsc_pkg::t_out_item r_out_item;

    adsc_pkg::t_level   r_floor;
    adsc_pkg::t_level   r_ceiling;

    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_advance;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_shift    = w_accept && (i_in_data.req_type == adsc_pkg::REQ_SAMPLE);

    for (genvar g = 0; g < SAMPLE_COUNT; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_cell_in[g] = i_in_data.sensor_value;
        end else begin : g_link
            assign w_cell_in[g] = w_cell_out[g-1];
        end
        adsc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_shift),
            .i_sample (w_cell_in[g]),
            .o_sample (w_cell_out[g])
        );
    end

    // oldest reading drops off the tail as the new one enters
    always_comb begin
        n_total = r_total - TOT_W'(w_cell_out[SAMPLE_COUNT-1])
                + TOT_W'(i_in_data.sensor_value);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (w_shift) begin
            r_total <= n_total;
        end
    end

    // exact floor(total / N) by rounded-up reciprocal
    assign w_prod = PROD_W'(r_total) * PROD_W'(RECIP[RECIP_W-1:0]);
    assign w_mean = w_prod[SHIFT_K +: adsc_pkg::LEVEL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= w_accept && (i_in_data.req_type == adsc_pkg::REQ_UPDATE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s1_mean <= w_mean;
        end
    end

    adsc_slew u_slew (
        .i_mean    (r_s1_mean),
        .i_duty    (r_duty),
        .i_floor   (r_floor),
        .i_ceiling (r_ceiling),
        .o_duty    (w_duty_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_duty <= w_duty_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid) begin
            r_out_item.duty_level <= w_duty_next;
            r_out_item.mean_level <= r_s1_mean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= adsc_pkg::DUTY_FLOOR_RST;
            r_ceiling <= adsc_pkg::DUTY_CEILING_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                adsc_pkg::CFG_DUTY_FLOOR:   r_floor   <= i_cfg_data;
                adsc_pkg::CFG_DUTY_CEILING: r_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

`default_nettype wire

// ----- src/adsc_cell.sv -----
// One cell of the sample history line: holds one reading and hands it to
// the next cell on every shift. Depends on adsc_pkg.
`default_nettype none

module adsc_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire adsc_pkg::t_level i_sample,
    output adsc_pkg::t_level     o_sample
);

    adsc_pkg::t_level r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

`default_nettype wire

// ----- src/adsc_slew.sv -----
// Clamp of the mean into [floor, ceiling] and one proportional slew step
// of the duty toward it. Depends on adsc_pkg.
`default_nettype none

module adsc_slew (
    input  wire adsc_pkg::t_level i_mean,
    input  wire adsc_pkg::t_level i_duty,
    input  wire adsc_pkg::t_level i_floor,
    input  wire adsc_pkg::t_level i_ceiling,
    output adsc_pkg::t_level     o_duty
);

    localparam int PROD_W = adsc_pkg::LEVEL_W + adsc_pkg::SLEW_RECIP_W;

    adsc_pkg::t_level  w_target;
    adsc_pkg::t_level  w_dist;
    adsc_pkg::t_level  w_step;
    logic [PROD_W-1:0] w_prod;

    always_comb begin
        // min then max: floor wins when it sits above the ceiling
        w_target = (i_mean < i_ceiling) ? i_mean : i_ceiling;
        if (w_target < i_floor) begin
            w_target = i_floor;
        end

        w_dist = (w_target > i_duty) ? (w_target - i_duty) : (i_duty - w_target);
        w_prod = PROD_W'(w_dist) * PROD_W'(adsc_pkg::SLEW_RECIP);
        w_step = adsc_pkg::t_level'(w_prod >> adsc_pkg::SLEW_SHIFT);
        if (w_step < adsc_pkg::MIN_STEP) begin
            w_step = adsc_pkg::MIN_STEP;
        end

        priority if (w_target > i_duty) begin
            o_duty = i_duty + w_step;
        end else if (w_target < i_duty) begin
            o_duty = i_duty - w_step;
        end else begin
            o_duty = i_duty;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_averaged_duty_slew_controller.sv -----
// Self-checking testbench for averaged_duty_slew_controller.
// Predicts each duty update from its own sample history and limit copies.
// Depends on adsc_pkg and the DUT only.
`timescale 1ns / 1ps

module tb_averaged_duty_slew_controller;

    localparam int HIST_DEPTH    = adsc_pkg::SAMPLE_COUNT_DEF;
    localparam int SUM_W         = 14;
    localparam int SLEW_DIV      = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 700;
    localparam int RANDOM_PHASES = 6;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int TIMEOUT_NS    = 2_000_000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    adsc_pkg::t_in_item   i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b1;
    adsc_pkg::t_out_item  o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [adsc_pkg::CFG_IDX_W-1:0] i_cfg_idx = adsc_pkg::CFG_DUTY_FLOOR;
    adsc_pkg::t_level     i_cfg_data  = '0;

    // predictor state
    adsc_pkg::t_level     sample_hist [HIST_DEPTH];
    int                   hist_slot;
    logic [SUM_W-1:0]     hist_sum;
    adsc_pkg::t_level     duty_model;
    adsc_pkg::t_level     floor_reg;
    adsc_pkg::t_level     ceil_reg;
    adsc_pkg::t_out_item  pending_duty [$];
    int                   fail_count = 0;

    // receiver pattern state
    int hold_req    = 0;
    int hold_ack    = 0;
    int hold_left   = 0;
    int rx_phase    = 0;
    int rx_period   = 1;
    int rx_stall    = 0;

    averaged_duty_slew_controller #(
        .SAMPLE_COUNT(HIST_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void note_fail(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endfunction

    function automatic adsc_pkg::t_level slew_toward(adsc_pkg::t_level cur,
                                                     adsc_pkg::t_level tgt);
        adsc_pkg::t_level gap;
        adsc_pkg::t_level step;
        if (tgt == cur) begin
            return cur;
        end
        gap = (tgt > cur) ? tgt - cur : cur - tgt;
        step = adsc_pkg::t_level'(gap / SLEW_DIV);
        if (step < adsc_pkg::MIN_STEP) begin
            step = adsc_pkg::MIN_STEP;
        end
        return (tgt > cur) ? cur + step : cur - step;
    endfunction

    // apply one accepted beat to the predictor
    function automatic void track_duty_item(adsc_pkg::t_in_item it);
        adsc_pkg::t_level    mean;
        adsc_pkg::t_level    target;
        adsc_pkg::t_out_item res;
        if (it.req_type == adsc_pkg::REQ_SAMPLE) begin
            hist_sum = hist_sum - SUM_W'(sample_hist[hist_slot]) + SUM_W'(it.sensor_value);
            sample_hist[hist_slot] = it.sensor_value;
            hist_slot = (hist_slot + 1) % HIST_DEPTH;
        end else begin
            mean   = adsc_pkg::t_level'(hist_sum / HIST_DEPTH);
            target = (mean < ceil_reg) ? mean : ceil_reg;
            if (target < floor_reg) begin
                target = floor_reg;
            end
            duty_model = slew_toward(duty_model, target);
            res.duty_level = duty_model;
            res.mean_level = mean;
            pending_duty.push_back(res);
        end
    endfunction

    task automatic send_item(input adsc_pkg::t_in_item it);
        i_in_data  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        track_duty_item(it);
    endtask

    task automatic send_sample(input adsc_pkg::t_level v);
        adsc_pkg::t_in_item it;
        it.req_type     = adsc_pkg::REQ_SAMPLE;
        it.sensor_value = v;
        send_item(it);
    endtask

    task automatic send_update();
        adsc_pkg::t_in_item it;
        it.req_type     = adsc_pkg::REQ_UPDATE;
        it.sensor_value = adsc_pkg::t_level'($urandom);
        send_item(it);
    endtask

    task automatic sender_gap(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // sender pause: nothing offered until every result is back and the pipe is quiet
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (pending_duty.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both limits, back to back; only called with the block idle
    task automatic write_limits(input adsc_pkg::t_level fl, input adsc_pkg::t_level cl);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= adsc_pkg::CFG_DUTY_FLOOR;
        i_cfg_data <= fl;
        @(posedge i_clk);
        floor_reg = fl;
        i_cfg_idx  <= adsc_pkg::CFG_DUTY_CEILING;
        i_cfg_data <= cl;
        @(posedge i_clk);
        ceil_reg = cl;
        i_cfg_we   <= 1'b0;
    endtask

    function automatic adsc_pkg::t_in_item random_item(int level, int update_pct);
        adsc_pkg::t_in_item it;
        int                 v;
        it.req_type = ($urandom_range(0, 99) < update_pct) ? adsc_pkg::REQ_UPDATE
                                                            : adsc_pkg::REQ_SAMPLE;
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom_range(0, adsc_pkg::LEVEL_MAX);
        end else begin
            v = level + $urandom_range(0, 40) - 20;
            v = (v < 0) ? 0 : (v > adsc_pkg::LEVEL_MAX) ? adsc_pkg::LEVEL_MAX : v;
        end
        it.sensor_value = adsc_pkg::t_level'(v);
        return it;
    endfunction

    // ---------------- tests ----------------

    // all-zero history right after reset: mean 0, target equals duty
    task automatic test_empty_history();
        send_update();
        wait_all_results();
    endtask

    task automatic test_full_scale();
        repeat (HIST_DEPTH) send_sample(adsc_pkg::t_level'(adsc_pkg::LEVEL_MAX));
        send_update();
        send_sample('0);
        send_update();
        wait_all_results();
    endtask

    // floor wins when set above the ceiling
    task automatic test_floor_over_ceiling();
        write_limits(adsc_pkg::t_level'(700), adsc_pkg::t_level'(300));
        send_update();
        wait_all_results();
    endtask

    // distance under the divisor steps by one; then target equal to duty
    task automatic test_small_step();
        adsc_pkg::t_level tgt;
        tgt = (duty_model >= 512) ? duty_model - 5 : duty_model + 5;
        write_limits(tgt, tgt);
        send_update();
        send_update();
        wait_all_results();
        write_limits(duty_model, duty_model);
        send_update();
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        int               level;
        int               burst_left;
        adsc_pkg::t_level fl;
        adsc_pkg::t_level cl;
        level      = $urandom_range(0, adsc_pkg::LEVEL_MAX);
        burst_left = 0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    fl = '0;
                    cl = adsc_pkg::t_level'(adsc_pkg::LEVEL_MAX);
                end
                1: begin
                    fl = adsc_pkg::t_level'(adsc_pkg::LEVEL_MAX);
                    cl = '0;
                end
                2: begin
                    fl = '0;
                    cl = '0;
                end
                3: begin
                    fl = adsc_pkg::t_level'(adsc_pkg::LEVEL_MAX);
                    cl = adsc_pkg::t_level'(adsc_pkg::LEVEL_MAX);
                end
                4: begin
                    fl = adsc_pkg::t_level'($urandom_range(0, adsc_pkg::LEVEL_MAX));
                    cl = adsc_pkg::t_level'($urandom_range(0, adsc_pkg::LEVEL_MAX));
                end
                default: begin
                    fl = adsc_pkg::t_level'($urandom_range(0, 511));
                    cl = adsc_pkg::t_level'($urandom_range(fl, adsc_pkg::LEVEL_MAX));
                end
            endcase
            wait_all_results();
            write_limits(fl, cl);
            for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
                if (burst_left == 0) begin
                    sender_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
                    burst_left = $urandom_range(1, 24);
                end
                if ($urandom_range(0, 19) == 0) begin
                    level = $urandom_range(0, adsc_pkg::LEVEL_MAX);
                end
                send_item(random_item(level, 30));
                burst_left--;
            end
        end
        wait_all_results();
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        int level;
        level = $urandom_range(0, adsc_pkg::LEVEL_MAX);
        hold_req <= hold_req + 1;
        repeat (40) send_item(random_item(level, 50));
        wait_all_results();
    endtask

    // ---------------- checking ----------------

    always @(posedge i_clk) begin : out_check
        adsc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_duty.size() == 0) begin
                note_fail($sformatf("unexpected beat duty=%0d mean=%0d",
                                    o_out_data.duty_level, o_out_data.mean_level));
            end else begin
                want = pending_duty.pop_front();
                if (o_out_data.duty_level !== want.duty_level) begin
                    note_fail($sformatf("duty_level expected %0d, got %0d",
                                        want.duty_level, o_out_data.duty_level));
                end
                if (o_out_data.mean_level !== want.mean_level) begin
                    note_fail($sformatf("mean_level expected %0d, got %0d",
                                        want.mean_level, o_out_data.mean_level));
                end
            end
        end
    end

    // receiver: random ready pattern, plus a long hold on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_phase == 0) begin
                rx_period = $urandom_range(1, 40);
                rx_stall  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rx_period - 1);
                rx_phase  = rx_period;
            end
            rx_phase--;
            i_out_ready <= (rx_phase >= rx_stall);
        end
    end

    initial begin
        int waited;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            sample_hist[k] = '0;
        end
        hist_slot  = 0;
        hist_sum   = '0;
        duty_model = '0;
        floor_reg  = adsc_pkg::DUTY_FLOOR_RST;
        ceil_reg   = adsc_pkg::DUTY_CEILING_RST;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_history();
        test_full_scale();
        test_floor_over_ceiling();
        test_small_step();
        test_random_traffic();
        test_backpressure();

        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_duty.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_duty.size() != 0) begin
            note_fail($sformatf("%0d expected results never arrived", pending_duty.size()));
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
